/* rtl/arpr_pkg.sv */
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared constants, types and the fixed-header table for the ARP responder.
// ----------------------------------------------------------------------------
package arpr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 1514;

    // Frame layout (byte offsets from the start of the Ethernet frame)
    localparam int ETH_TYPE_OFFSET = 12;
    localparam int ETH_HDR_LEN     = 14;
    localparam int ARP_BODY_LEN    = 28;
    localparam int ARP_SHA_START   = ETH_HDR_LEN + 8;
    localparam int ARP_SPA_START   = ETH_HDR_LEN + 14;
    localparam int ARP_TPA_START   = ETH_HDR_LEN + 24;
    localparam int ARP_FRAME_LEN   = ETH_HDR_LEN + ARP_BODY_LEN;

    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  ARP_HLEN_MAC   = 8'd6;
    localparam logic [7:0]  ARP_PLEN_IPV4  = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;

    localparam int IDX_W = $clog2(ARP_BODY_LEN);

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_IP  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_MAC = 1'd1;

    localparam logic [31:0] LOCAL_IP_RST  = 32'h0A00_020A;
    localparam logic [47:0] LOCAL_MAC_RST = 48'h0;

    // Request handed from the parser to the reply generator
    typedef struct packed {
        logic        start;
        logic [47:0] sha;
        logic [31:0] spa;
    } reply_req_t;

    // Expected byte k of the fixed ARP request header
    function automatic logic [7:0] hdr_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0: b = ARP_HTYPE_ETH[15:8];
            3'd1: b = ARP_HTYPE_ETH[7:0];
            3'd2: b = ARP_PTYPE_IPV4[15:8];
            3'd3: b = ARP_PTYPE_IPV4[7:0];
            3'd4: b = ARP_HLEN_MAC;
            3'd5: b = ARP_PLEN_IPV4;
            3'd6: b = ARP_OP_REQUEST[15:8];
            default: b = ARP_OP_REQUEST[7:0];
        endcase
        return b;
    endfunction

endpackage

/* rtl/arpr_parser.sv */
// ----------------------------------------------------------------------------
// arpr_parser
// Tracks the byte position of the received frame, captures the ethertype and
// ARP fields, and flags a qualifying request on its final byte.
// ----------------------------------------------------------------------------
module arpr_parser #(
    parameter int MAX_FRAME_BYTES = arpr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic [31:0]         local_ip,
    output logic                may_finish,
    output arpr_pkg::reply_req_t req
);
    import arpr_pkg::*;

    localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

    logic [PosW-1:0] pos_reg, pos_next;
    logic [15:0]     type_reg, type_next;
    logic            hv_reg, hv_next;
    logic [47:0]     sha_reg, sha_next;
    logic [31:0]     spa_reg, spa_next;
    logic            tm_reg, tm_next;

    logic [PosW-1:0] hdr_off, tgt_off;
    logic [7:0]      ip_byte;
    logic            qualify;

    assign hdr_off = pos_reg - PosW'(ETH_HDR_LEN);
    assign tgt_off = pos_reg - PosW'(ARP_TPA_START);

    always_comb begin
        case (tgt_off[1:0])
            2'd0: ip_byte = local_ip[31:24];
            2'd1: ip_byte = local_ip[23:16];
            2'd2: ip_byte = local_ip[15:8];
            default: ip_byte = local_ip[7:0];
        endcase
    end

    always_comb begin
        pos_next  = pos_reg;
        type_next = type_reg;
        hv_next   = hv_reg;
        sha_next  = sha_reg;
        spa_next  = spa_reg;
        tm_next   = tm_reg;
        if (pos_reg < PosMax) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == PosW'(ETH_TYPE_OFFSET)) begin
                type_next = {in_byte, type_reg[7:0]};
            end else if (pos_reg == PosW'(ETH_TYPE_OFFSET + 1)) begin
                type_next = {type_reg[15:8], in_byte};
            end else if (pos_reg >= PosW'(ETH_HDR_LEN) && pos_reg < PosW'(ARP_SHA_START)) begin
                if (in_byte != hdr_byte(hdr_off[2:0])) begin
                    hv_next = 1'b0;
                end
            end else if (pos_reg >= PosW'(ARP_SHA_START) && pos_reg < PosW'(ARP_SPA_START)) begin
                sha_next = {sha_reg[39:0], in_byte};
            end else if (pos_reg >= PosW'(ARP_SPA_START)
                         && pos_reg < PosW'(ARP_SPA_START + 4)) begin
                spa_next = {spa_reg[23:0], in_byte};
            end else if (pos_reg >= PosW'(ARP_TPA_START) && pos_reg < PosW'(ARP_FRAME_LEN)) begin
                if (in_byte != ip_byte) begin
                    tm_next = 1'b0;
                end
            end
        end
    end

    assign qualify = pos_next >= PosW'(ARP_FRAME_LEN) && type_next == ETHERTYPE_ARP
                     && hv_next && tm_next;

    assign req.start = in_accept && in_last && qualify;
    assign req.sha   = sha_next;
    assign req.spa   = spa_next;

    // A frame can only end with a reply once this byte lands at or past the body end
    assign may_finish = pos_reg >= PosW'(ARP_FRAME_LEN - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            type_reg <= '0;
            hv_reg   <= 1'b1;
            sha_reg  <= '0;
            spa_reg  <= '0;
            tm_reg   <= 1'b1;
        end else if (in_accept) begin
            if (in_last) begin
                pos_reg  <= '0;
                type_reg <= '0;
                hv_reg   <= 1'b1;
                sha_reg  <= '0;
                spa_reg  <= '0;
                tm_reg   <= 1'b1;
            end else begin
                pos_reg  <= pos_next;
                type_reg <= type_next;
                hv_reg   <= hv_next;
                sha_reg  <= sha_next;
                spa_reg  <= spa_next;
                tm_reg   <= tm_next;
            end
        end
    end

endmodule

/* rtl/arpr_reply.sv */
// ----------------------------------------------------------------------------
// arpr_reply
// Holds a snapshot of the reply fields and streams the 28-byte ARP reply.
// ----------------------------------------------------------------------------
module arpr_reply (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  arpr_pkg::reply_req_t req,
    input  logic [31:0]          local_ip,
    input  logic [47:0]          local_mac,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import arpr_pkg::*;

    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [47:0]       mac_reg, sha_reg;
    logic [31:0]       ip_reg, spa_reg;
    logic [ARP_BODY_LEN*8-1:0] body;
    logic [IDX_W-1:0]  sel;
    logic              take, last_idx;

    // Reply body, first byte in the top bits
    assign body = {hdr_byte(3'd0), hdr_byte(3'd1), hdr_byte(3'd2), hdr_byte(3'd3),
                   hdr_byte(3'd4), hdr_byte(3'd5), ARP_OP_REPLY,
                   mac_reg, ip_reg, sha_reg, spa_reg};

    assign sel      = IDX_W'(ARP_BODY_LEN - 1) - idx_reg;
    assign last_idx = idx_reg == IDX_W'(ARP_BODY_LEN - 1);
    assign take     = busy_reg && m_tready;

    assign m_tvalid = busy_reg;
    assign m_tdata  = body[{sel, 3'b000} +: 8];
    assign m_tlast  = last_idx;
    assign busy     = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (take) begin
            if (last_idx) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Capture registers as they stand on the final request byte
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mac_reg <= local_mac;
            ip_reg  <= local_ip;
            sha_reg <= req.sha;
            spa_reg <= req.spa;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("reply request while a reply is in flight");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !m_tready) |=> (busy_reg && $stable(idx_reg)))
        else $error("reply index moved during stall");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && last_idx) |=> !busy_reg)
        else $error("reply still busy after final item");

    a_start_first: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> (busy_reg && idx_reg == '0))
        else $error("reply did not start at first byte");
`endif

endmodule

/* rtl/arp_request_responder.sv */
// ----------------------------------------------------------------------------
// arp_request_responder
// Answers Ethernet/IPv4 ARP requests for the local address with an ARP reply.
// ----------------------------------------------------------------------------
//   channel  direction  payload                         end marker
//   s_       in         tdata[7:0] frame byte           tlast = frame end
//   m_       out        tdata[7:0] reply byte           tlast = 28th reply byte
//   cfg_     in         wdata: local_ip (0), local_mac (1)
//
// One frame byte is taken per cycle; a qualifying request starts the 28-byte
// reply on the cycle after its final byte, one reply byte per cycle.
// s_tready drops only when a frame reaches the ARP body end while the previous
// reply is still waiting on m_tready; otherwise input never stalls.
// Reset (aresetn low, synchronous) clears frame state and any pending reply.
// ----------------------------------------------------------------------------
module arp_request_responder #(
    parameter int MAX_FRAME_BYTES = arpr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] frame_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] reply_byte
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [arpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [arpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import arpr_pkg::*;

    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;
    logic        in_accept, may_finish, busy;
    reply_req_t  req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg  <= LOCAL_IP_RST;
            local_mac_reg <= LOCAL_MAC_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LOCAL_IP:  local_ip_reg  <= cfg_wdata[31:0];
                REG_LOCAL_MAC: local_mac_reg <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // Hold input only when this byte could trigger a reply that has no room yet
    assign s_tready  = !busy || !may_finish;
    assign in_accept = s_tvalid && s_tready;

    arpr_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .local_ip  (local_ip_reg),
        .may_finish(may_finish),
        .req       (req)
    );

    arpr_reply u_reply (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .local_ip (local_ip_reg),
        .local_mac(local_mac_reg),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* dv/arp_request_responder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_request_responder_tb
// Self-checking bench for the ARP responder. Ethernet frames are streamed
// byte by byte into the slave channel: first a table of hand-built frames
// (good requests, every reason to stay silent, padding, an overlong frame),
// then random frames, mostly valid requests with random addresses, the rest
// corrupted, truncated or noise. A software copy of the responder predicts
// every reply byte; the master channel is checked item by item against it.
// The local addresses are reloaded after the table, and both channels idle
// and stall at random, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module arp_request_responder_tb;
    import arpr_pkg::*;

    // Any bound from the ARP frame length up gives the same replies; a small
    // one keeps the overlong frame short.
    localparam int MAX_BYTES  = 48;
    localparam int HALF_CLK   = 6;
    localparam int RESET_CYC  = 10;
    localparam int DRAIN_WAIT = 60;
    localparam int HOLD_CYC   = 400;
    localparam int RUN_LIMIT  = 6_000_000;  // ns

    localparam logic [63:0] ARP_REQ_HDR = {ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_MAC,
                                           ARP_PLEN_IPV4, ARP_OP_REQUEST};

    typedef enum int {
        FK_REQUEST, FK_SHORT, FK_BAD_TYPE, FK_BAD_HDR, FK_BAD_OP, FK_BAD_TARGET,
        FK_NOISE, FK_OVERLONG
    } frame_kind_t;

    // extra: padding; length for FK_SHORT/FK_NOISE; overrun for FK_OVERLONG
    typedef struct packed {
        frame_kind_t kind;
        int          extra;
        logic [47:0] sha;
        logic [31:0] spa;
        int          want_reply;  // 1 reply, 0 silent, -1 predictor only
    } frame_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_beat_t;

    localparam int DIR_ROWS = 8;
    localparam frame_row_t DIR_TABLE [DIR_ROWS] = '{
        '{FK_REQUEST,     6, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,  1},
        '{FK_SHORT,      41, 48'h0011_2233_4455, 32'h0A00_0201,  0},
        '{FK_SHORT,       1, 48'h0011_2233_4455, 32'h0A00_0201,  0},
        '{FK_BAD_TYPE,    0, 48'h0011_2233_4455, 32'h0A00_0201,  0},
        '{FK_BAD_HDR,     0, 48'h0011_2233_4455, 32'h0A00_0201,  0},
        '{FK_BAD_OP,      0, 48'h0011_2233_4455, 32'h0A00_0201,  0},
        '{FK_BAD_TARGET,  0, 48'h0011_2233_4455, 32'h0A00_0201,  0},
        '{FK_OVERLONG,    5, 48'h0000_0000_0000, 32'h0000_0000,  1}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] frame_byte
    logic                  s_tlast   = 1'b0; // frame_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] reply_byte
    logic                  m_tlast;          // reply_end
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // responder copy: registers and per-frame state
    logic [31:0] lip_shadow  = LOCAL_IP_RST;
    logic [47:0] lmac_shadow = LOCAL_MAC_RST;
    int          rx_pos       = 0;
    logic [15:0] rx_ethertype = '0;
    logic        rx_hdr_ok    = 1'b1;
    logic [47:0] rx_sha       = '0;
    logic [31:0] rx_spa       = '0;
    logic        rx_tpa_ok    = 1'b1;

    reply_beat_t reply_expect_q [$];
    reply_beat_t head_beat;
    logic [7:0]  frame_bytes [$];

    int errors      = 0;
    int bytes_sent  = 0;
    int arp_replies = 0;
    int tx_idle_pct = 6;
    int rx_idle_pct = 78;
    int hold_req    = 0;
    int hold_left   = 0;

    arp_request_responder #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #(HALF_CLK) aclk = ~aclk;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Advance the responder copy by one accepted frame byte.
    function automatic void absorb_frame_byte(input logic [7:0] b, input logic last);
        int           k;
        logic [223:0] reply_img;
        reply_beat_t  beat;
        if (rx_pos < MAX_BYTES) begin
            if (rx_pos == ETH_TYPE_OFFSET) begin
                rx_ethertype[15:8] = b;
            end else if (rx_pos == ETH_TYPE_OFFSET + 1) begin
                rx_ethertype[7:0] = b;
            end else if (rx_pos >= ETH_HDR_LEN && rx_pos < ARP_FRAME_LEN) begin
                k = rx_pos - ETH_HDR_LEN;
                if (k < 8) begin
                    if (b != ARP_REQ_HDR[8*(7-k) +: 8]) rx_hdr_ok = 1'b0;
                end else if (k < 14) begin
                    rx_sha = {rx_sha[39:0], b};
                end else if (k < 18) begin
                    rx_spa = {rx_spa[23:0], b};
                end else if (k >= 24 && b != lip_shadow[8*(27-k) +: 8]) begin
                    rx_tpa_ok = 1'b0;
                end
            end
            rx_pos++;
        end
        if (last) begin
            if (rx_pos >= ARP_FRAME_LEN && rx_ethertype == ETHERTYPE_ARP &&
                rx_hdr_ok && rx_tpa_ok) begin
                reply_img = {ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_MAC, ARP_PLEN_IPV4,
                             ARP_OP_REPLY, lmac_shadow, lip_shadow, rx_sha, rx_spa};
                for (k = 0; k < ARP_BODY_LEN; k++) begin
                    beat.data = reply_img[8*(ARP_BODY_LEN-1-k) +: 8];
                    beat.last = (k == ARP_BODY_LEN - 1);
                    reply_expect_q.push_back(beat);
                end
                arp_replies++;
            end
            rx_pos       = 0;
            rx_ethertype = '0;
            rx_hdr_ok    = 1'b1;
            rx_sha       = '0;
            rx_spa       = '0;
            rx_tpa_ok    = 1'b1;
        end
    endfunction

    // Fill frame_bytes with one frame; requests target the current local IP.
    task automatic build_frame(input frame_kind_t kind, input int extra,
                               input logic [47:0] sha, input logic [31:0] spa);
        logic [335:0] img;
        int           len;
        int           pad;
        int           pos;
        int           i;
        img = {rand48(), rand48(), ETHERTYPE_ARP, ARP_REQ_HDR, sha, spa, rand48(), lip_shadow};
        len = ARP_FRAME_LEN;
        pad = extra;
        pos = -1;
        case (kind)
            FK_SHORT: begin
                len = extra;
                pad = 0;
            end
            FK_BAD_TYPE:   pos = $urandom_range(ETH_TYPE_OFFSET, ETH_TYPE_OFFSET + 1);
            FK_BAD_HDR:    pos = $urandom_range(ETH_HDR_LEN, ETH_HDR_LEN + 5);
            FK_BAD_OP:     pos = $urandom_range(ETH_HDR_LEN + 6, ETH_HDR_LEN + 7);
            FK_BAD_TARGET: pos = $urandom_range(ARP_TPA_START, ARP_FRAME_LEN - 1);
            FK_OVERLONG:   pad = MAX_BYTES - ARP_FRAME_LEN + extra;
            default: ;
        endcase
        // flip at least one bit so the field can no longer match
        if (pos >= 0) begin
            img[8*(ARP_FRAME_LEN-1-pos) +: 8] = img[8*(ARP_FRAME_LEN-1-pos) +: 8] ^
                                                8'($urandom_range(1, 255));
        end
        frame_bytes.delete();
        if (kind == FK_NOISE) begin
            for (i = 0; i < extra; i++) frame_bytes.push_back(8'($urandom));
        end else begin
            for (i = 0; i < len; i++) frame_bytes.push_back(img[8*(ARP_FRAME_LEN-1-i) +: 8]);
            for (i = 0; i < pad; i++) frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_bytes[i];
            s_tlast  <= (i == frame_bytes.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            absorb_frame_byte(frame_bytes[i], i == frame_bytes.size() - 1);
            bytes_sent++;
        end
    endtask

    // Drop valid, let every expected reply drain, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (reply_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic load_addresses(input logic [31:0] ip, input logic [47:0] mac);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LOCAL_IP;
        cfg_wdata <= {16'h0, ip};
        @(posedge aclk);
        cfg_addr  <= REG_LOCAL_MAC;
        cfg_wdata <= mac;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        lip_shadow  = ip;
        lmac_shadow = mac;
    endtask

    // Receiver: check each reply item, then pick next cycle's ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (reply_expect_q.size() == 0) begin
                flag_error($sformatf("unexpected reply item %02h last %0b", m_tdata, m_tlast));
            end else begin
                head_beat = reply_expect_q.pop_front();
                if (m_tdata !== head_beat.data)
                    flag_error($sformatf("reply_byte %02h, want %02h", m_tdata, head_beat.data));
                if (m_tlast !== head_beat.last)
                    flag_error($sformatf("reply_end %0b, want %0b", m_tlast, head_beat.last));
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("ERROR: run did not finish in time");
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          row;
        int          r;
        int          extra;
        int          start_bytes;
        int          start_replies;
        frame_kind_t kind;

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames, registers at their reset values
        for (row = 0; row < DIR_ROWS; row++) begin
            start_replies = arp_replies;
            build_frame(DIR_TABLE[row].kind, DIR_TABLE[row].extra,
                        DIR_TABLE[row].sha, DIR_TABLE[row].spa);
            send_frame();
            if (DIR_TABLE[row].want_reply >= 0 &&
                (arp_replies - start_replies) != DIR_TABLE[row].want_reply)
                flag_error($sformatf("directed frame %0d: reply count %0d, table says %0d",
                                     row, arp_replies - start_replies,
                                     DIR_TABLE[row].want_reply));
        end

        // random frames, sender mostly idle; stop at 40+ bytes and 1+ reply
        wait_idle();
        tx_idle_pct = 78;
        rx_idle_pct = 6;
        load_addresses($urandom, 48'hFFFF_FFFF_FFFF);

        start_bytes   = bytes_sent;
        start_replies = arp_replies;
        while (bytes_sent - start_bytes < 40 || arp_replies - start_replies < 1) begin
            r     = $urandom_range(99);
            extra = $urandom_range(4);
            if (r < 62) begin
                kind = FK_REQUEST;
                if ($urandom_range(9) == 0) extra = $urandom_range(30);
            end else if (r < 68) begin
                kind  = FK_SHORT;
                extra = $urandom_range(1, ARP_FRAME_LEN - 1);
            end else if (r < 73) begin
                kind = FK_BAD_TYPE;
            end else if (r < 79) begin
                kind = FK_BAD_HDR;
            end else if (r < 84) begin
                kind = FK_BAD_OP;
            end else if (r < 90) begin
                kind = FK_BAD_TARGET;
            end else begin
                kind  = FK_NOISE;
                extra = $urandom_range(1, 48);
            end
            build_frame(kind, extra, rand48(), $urandom);
            send_frame();
        end

        // no idling; hold the receiver off while the last reply is pending,
        // so the next request stalls at its body end
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = HOLD_CYC;
        build_frame(FK_REQUEST, $urandom_range(3), rand48(), $urandom);
        send_frame();

        wait_idle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* arp_request_responder.f */
rtl/arpr_pkg.sv
rtl/arpr_parser.sv
rtl/arpr_reply.sv
rtl/arp_request_responder.sv
dv/arp_request_responder_tb.sv
